### hdl/assert_macros.svh
// Assertion shorthands for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define PIF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, quiet during reset.
`define PIF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### hdl/pif_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pif_pkg;

  localparam int DEF_NUM_VARS = 4;
  localparam int MAX_VARS     = 4;
  localparam int CUBE_W       = 4;
  localparam int MINTERM_W    = 16;
  localparam int MASK_DEPTH   = 16;
  localparam int MAX_OUT      = 32;
  localparam int CNT_W        = 6;

  // List the don't-care masks of nv variables, fewest free bits first,
  // then ascending; unused tail entries stay zero
  function automatic logic [MASK_DEPTH-1:0][CUBE_W-1:0] mask_order(int nv);
    logic [MASK_DEPTH-1:0][CUBE_W-1:0] tbl;
    int idx;
    int ones;
    tbl = '0;
    idx = 0;
    for (int dc = 0; dc <= MAX_VARS; dc++) begin
      for (int m = 0; m < MASK_DEPTH; m++) begin
        ones = 0;
        for (int b = 0; b < CUBE_W; b++) begin
          ones = ones + ((m >> b) & 1);
        end
        if ((m < (1 << nv)) && (ones == dc)) begin
          tbl[idx[3:0]] = CUBE_W'(m);
          idx = idx + 1;
        end
      end
    end
    return tbl;
  endfunction

endpackage

`default_nettype wire

### hdl/pif_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Minterm mask channel
interface pif_in_if
  import pif_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [MINTERM_W-1:0] minterm_set;

  modport source (output valid, output minterm_set, input ready);
  modport sink   (input valid, input minterm_set, output ready);
endinterface

// Prime implicant channel
interface pif_out_if
  import pif_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CUBE_W-1:0] cube_value;
  logic [CUBE_W-1:0] cube_free_mask;
  logic              none_found;
  logic              last_result;

  modport source (output valid, output cube_value, output cube_free_mask,
                  output none_found, output last_result, input ready);
  modport sink   (input valid, input cube_value, input cube_free_mask,
                  input none_found, input last_result, output ready);
endinterface

`default_nettype wire

### hdl/prime_implicant_finder.sv
// Channel    Role    Payload
// minterms   sink    minterm_set[15:0]
// cubes      source  cube_value[3:0], cube_free_mask[3:0], none_found, last_result
//
// One cube per cycle goes through the shared prime test unit, in the order
// the results leave, while no prime waits for a stalled output. An empty
// on-set goes straight to a single none_found word. Each prime is held one
// step so the final one can carry last_result; a stalled output holds the
// scan. Reset is synchronous and clears control only.
`timescale 1ns / 1ps
`default_nettype none

module prime_implicant_finder
  import pif_pkg::*;
#(
  parameter int NUM_VARS = DEF_NUM_VARS
) (
  input  logic       clk,
  input  logic       rst,
  pif_in_if.sink     minterms,
  pif_out_if.source  cubes
);

  localparam int SPACE = 1 << NUM_VARS;
  localparam logic [CUBE_W-1:0] FULL = CUBE_W'(SPACE - 1);
  localparam logic [MASK_DEPTH-1:0][CUBE_W-1:0] MASK_ORDER = mask_order(NUM_VARS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]          state;
  logic [SPACE-1:0]    onset;
  logic [NUM_VARS-1:0] rank;
  logic [CUBE_W-1:0]   cur_val;
  logic [CNT_W-1:0]    count;
  logic                pend_valid;
  logic [CUBE_W-1:0]   pend_val;
  logic [CUBE_W-1:0]   pend_mask;
  logic                pend_none;
  logic                out_valid;
  logic [CUBE_W-1:0]   out_val;
  logic [CUBE_W-1:0]   out_mask;
  logic                out_none;
  logic                out_last;

  logic [CUBE_W-1:0]   cur_mask;
  logic [CUBE_W:0]     step_sum;
  logic [CUBE_W-1:0]   val_next;
  logic                val_wrap;
  logic                last_cube;
  logic                is_prime;
  logic                in_acc;
  logic                out_free;
  logic                hit;
  logic                stall;
  logic                push;
  logic                flush;
  logic [SPACE-1:0]    new_onset;

  // Current cube: mask from the ordered table, value from the walk
  assign cur_mask  = MASK_ORDER[CUBE_W'(rank)];
  assign step_sum  = {1'b0, cur_val | cur_mask | ~FULL} + (CUBE_W+1)'(1);
  assign val_next  = step_sum[CUBE_W-1:0] & ~cur_mask & FULL;
  assign val_wrap  = step_sum[CUBE_W];
  assign last_cube = val_wrap && (rank == NUM_VARS'(SPACE - 1));

  pif_prime_unit #(
    .NUM_VARS (NUM_VARS)
  ) u_prime (
    .onset     (onset),
    .cube_val  (cur_val),
    .cube_mask (cur_mask),
    .is_prime  (is_prime)
  );

  assign new_onset = minterms.minterm_set[SPACE-1:0];
  assign in_acc    = minterms.valid && minterms.ready;
  assign out_free  = !out_valid || cubes.ready;
  assign hit       = (state == ST_SCAN) && is_prime;
  assign stall     = hit && pend_valid && !out_free;
  assign push      = hit && pend_valid && out_free;
  assign flush     = (state == ST_FLUSH) && out_free;

  // Sequencer, held prime and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      count      <= '0;
    end else begin
      // Load the output from the held prime, or drop a taken word
      if (push || flush) begin
        out_valid <= 1'b1;
        out_val   <= pend_val;
        out_mask  <= pend_mask;
        out_none  <= pend_none;
        out_last  <= flush;
      end else if (cubes.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            onset   <= new_onset;
            rank    <= '0;
            cur_val <= '0;
            count   <= '0;
            if (new_onset == '0) begin
              pend_valid <= 1'b1;
              pend_val   <= '0;
              pend_mask  <= '0;
              pend_none  <= 1'b1;
              state      <= ST_FLUSH;
            end else begin
              pend_valid <= 1'b0;
              state      <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // Advance one cube unless a prime waits for the output
          if (!stall) begin
            cur_val <= val_next;
            if (val_wrap) begin
              rank <= rank + 1'b1;
            end
            if (hit) begin
              pend_valid <= 1'b1;
              pend_val   <= cur_val;
              pend_mask  <= cur_mask;
              pend_none  <= 1'b0;
              count      <= count + 1'b1;
            end
            if (last_cube || (hit && count == CNT_W'(MAX_OUT - 1))) begin
              state <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign minterms.ready       = (state == ST_IDLE);
  assign cubes.valid          = out_valid;
  assign cubes.cube_value     = out_val;
  assign cubes.cube_free_mask = out_mask;
  assign cubes.none_found     = out_none;
  assign cubes.last_result    = out_last;

endmodule

`default_nettype wire

### hdl/pif_prime_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Prime test of one cube against the on-set: the cube must be an implicant,
// and no single-variable expansion of it may be one.
module pif_prime_unit
  import pif_pkg::*;
#(
  parameter int NUM_VARS = DEF_NUM_VARS
) (
  input  logic [(1<<NUM_VARS)-1:0] onset,
  input  logic [CUBE_W-1:0]        cube_val,
  input  logic [CUBE_W-1:0]        cube_mask,
  output logic                     is_prime
);

  localparam int SPACE = 1 << NUM_VARS;
  localparam logic [CUBE_W-1:0] FULL = CUBE_W'(SPACE - 1);

  // True when every minterm under the cube is in the on-set
  function automatic logic covered(logic [SPACE-1:0] on, logic [CUBE_W-1:0] v,
                                   logic [CUBE_W-1:0] m);
    logic ok;
    logic [CUBE_W-1:0] kk;
    ok = 1'b1;
    for (int k = 0; k < SPACE; k++) begin
      kk = CUBE_W'(k);
      if (((kk & ~m & FULL) == v) && !on[k]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // Check the cube, then try freeing each fixed variable
  always_comb begin : prime_chk
    logic [CUBE_W-1:0] bitv;
    is_prime = covered(onset, cube_val, cube_mask);
    for (int b = 0; b < NUM_VARS; b++) begin
      bitv = CUBE_W'(1) << b;
      if (!cube_mask[b] && covered(onset, cube_val & ~bitv, cube_mask | bitv)) begin
        is_prime = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/pif_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pif_checker
  import pif_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CUBE_W-1:0] cube_value,
  input logic [CUBE_W-1:0] cube_free_mask,
  input logic              none_found,
  input logic              last_result
);

  logic in_acc;
  logic out_stall;

  assign in_acc    = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  // A stalled word stays offered
  `PIF_ASSERT_NXT(a_out_hold, clk, rst, out_stall, out_valid)
  // Empty on-set gives a single all-zero closing word
  `PIF_ASSERT_IMP(a_none_word, clk, rst, out_valid && none_found,
                  last_result && cube_value == '0 && cube_free_mask == '0)
  // Value bits are clear under the don't-care mask
  `PIF_ASSERT_IMP(a_cube_form, clk, rst, out_valid, (cube_value & cube_free_mask) == '0)
  // One word at a time: the input closes right after an accept
  `PIF_ASSERT_NXT(a_one_busy, clk, rst, in_acc, !in_ready)

endmodule

bind prime_implicant_finder pif_checker u_pif_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (minterms.valid),
  .in_ready       (minterms.ready),
  .out_valid      (cubes.valid),
  .out_ready      (cubes.ready),
  .cube_value     (cubes.cube_value),
  .cube_free_mask (cubes.cube_free_mask),
  .none_found     (cubes.none_found),
  .last_result    (cubes.last_result)
);

`default_nettype wire

### test/prime_implicant_finder_tb.sv
`timescale 1ns / 1ps

module prime_implicant_finder_tb
  import pif_pkg::*;
();

  localparam int NV           = DEF_NUM_VARS;
  localparam int SPACE        = 1 << NV;
  localparam int RANDOM_WORDS = 190;
  localparam int CALM_WORDS   = 40;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 1_000_000;

  // Extremes, single minterms, parity, half-spaces and a few irregular maps
  localparam logic [MINTERM_W-1:0] DIRECTED [20] = '{
    16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h0000, 16'h0000,
    16'h6996, 16'h9669, 16'h00FF, 16'h0F0F, 16'h3333, 16'h5555,
    16'hAAAA, 16'h7FFF, 16'hFFFE, 16'h8001, 16'h1248, 16'h7EBD,
    16'hFFFF, 16'hE817
  };

  typedef struct packed {
    logic [CUBE_W-1:0] cube_value;
    logic [CUBE_W-1:0] cube_free_mask;
    logic              none_found;
    logic              last_result;
  } cube_t;

  class cube_scoreboard;
    cube_t expected_cubes[$];
    int    mismatches;

    function new();
      mismatches = 0;
    endfunction

    // True when every minterm under the cube lies in the on-set
    function bit within_onset(logic [MINTERM_W-1:0] onset, int value, int free_mask);
      for (int k = 0; k < SPACE; k++) begin
        if ((((k & ~free_mask) & (SPACE - 1)) == value) && !onset[k]) return 0;
      end
      return 1;
    endfunction

    // An implicant that cannot grow by freeing one more variable
    function bit is_prime(logic [MINTERM_W-1:0] onset, int value, int free_mask);
      if (!within_onset(onset, value, free_mask)) return 0;
      for (int b = 0; b < NV; b++) begin
        if (((free_mask >> b) & 1) == 0 &&
            within_onset(onset, value & ~(1 << b), free_mask | (1 << b))) return 0;
      end
      return 1;
    endfunction

    // Queue the prime implicants of an accepted word, in emission order
    function void note_minterms(logic [MINTERM_W-1:0] word);
      logic [MINTERM_W-1:0] onset;
      cube_t                cube;
      cube_t                found[$];
      onset = word & MINTERM_W'((1 << SPACE) - 1);
      if (onset == '0) begin
        cube = '{cube_value: '0, cube_free_mask: '0, none_found: 1'b1, last_result: 1'b1};
        expected_cubes.push_back(cube);
        return;
      end
      for (int dc = 0; dc <= NV; dc++) begin
        for (int m = 0; m < SPACE; m++) begin
          if ($countones(m) != dc) continue;
          for (int v = 0; v < SPACE; v++) begin
            if ((v & m) != 0) continue;
            if (!is_prime(onset, v, m)) continue;
            if (found.size() < MAX_OUT) begin
              cube = '{cube_value: CUBE_W'(v), cube_free_mask: CUBE_W'(m),
                       none_found: 1'b0, last_result: 1'b0};
              found.push_back(cube);
            end
          end
        end
      end
      found[found.size() - 1].last_result = 1'b1;
      foreach (found[i]) expected_cubes.push_back(found[i]);
    endfunction

    // Compare a delivered cube with the oldest expectation
    function void check_cube(cube_t got);
      cube_t want;
      if (expected_cubes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected cube value=%h mask=%h none=%b last=%b", $time,
                   got.cube_value, got.cube_free_mask, got.none_found, got.last_result);
        return;
      end
      want = expected_cubes.pop_front();
      if (got.cube_value !== want.cube_value || got.cube_free_mask !== want.cube_free_mask ||
          got.none_found !== want.none_found || got.last_result !== want.last_result) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp v=%h m=%h n=%b l=%b, got v=%h m=%h n=%b l=%b",
                   $time, want.cube_value, want.cube_free_mask, want.none_found,
                   want.last_result, got.cube_value, got.cube_free_mask, got.none_found,
                   got.last_result);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   calm;
  int   stall_left;
  int   cycle_count;

  cube_scoreboard sb = new;

  pif_in_if  minterms_if ();
  pif_out_if cubes_if ();

  prime_implicant_finder #(
    .NUM_VARS (NV)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .minterms (minterms_if),
    .cubes    (cubes_if)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the cube channel in random bursts, none once the run goes calm
  always @(negedge clk) begin
    if (stall_left > 0) begin
      cubes_if.ready = 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      cubes_if.ready = 1'b0;
      stall_left = $urandom_range(0, 18);
    end else begin
      cubes_if.ready = 1'b1;
    end
  end

  // Check every cube word taken from the block
  always @(posedge clk) begin
    if (!rst && cubes_if.valid && cubes_if.ready)
      sb.check_cube(cube_t'({cubes_if.cube_value, cubes_if.cube_free_mask,
                             cubes_if.none_found, cubes_if.last_result}));
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** prime_implicant_finder: FAILED **");
      $finish;
    end
  end

  // Offer one minterm word and hold it until taken; returns on a falling edge
  task automatic send_word(input logic [MINTERM_W-1:0] word);
    minterms_if.valid       = 1'b1;
    minterms_if.minterm_set = word;
    do @(posedge clk); while (!minterms_if.ready);
    sb.note_minterms(word);
    @(negedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    minterms_if.valid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_all_cubes();
    minterms_if.valid = 1'b0;
    while (sb.expected_cubes.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Mix sparse, dense and uniform on-sets, with a few empty and full ones
  function automatic logic [MINTERM_W-1:0] random_onset();
    logic [MINTERM_W-1:0] a, b, c;
    a = MINTERM_W'($urandom);
    b = MINTERM_W'($urandom);
    c = MINTERM_W'($urandom);
    case ($urandom_range(0, 15))
      0:       return $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
      1, 2, 3: return a & b;
      4, 5:    return a & b & c;
      6, 7, 8: return a | b;
      9:       return a | b | c;
      10:      return MINTERM_W'(1) << $urandom_range(0, MINTERM_W - 1);
      default: return a;
    endcase
  endfunction

  initial begin
    clk                     = 1'b0;
    rst                     = 1'b1;
    calm                    = 1'b0;
    stall_left              = 0;
    cycle_count             = 0;
    minterms_if.valid       = 1'b0;
    minterms_if.minterm_set = '0;
    cubes_if.ready          = 1'b0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed words
    foreach (DIRECTED[i]) begin
      if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 19));
      send_word(DIRECTED[i]);
    end

    // Hold off until the block has emptied
    wait_all_cubes();

    // Random words, idling dropped for the tail
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
      if (!calm && $urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 19));
      send_word(random_onset());
    end

    wait_all_cubes();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.mismatches == 0 && sb.expected_cubes.size() == 0) begin
      $display("** prime_implicant_finder: PASSED **");
    end else begin
      $display("** prime_implicant_finder: FAILED **");
    end
    $finish;
  end

endmodule
